[hdl/ihct_pkg.sv]
// package for the identity hash code table: widths, codes, request and result types
// no dependencies
package ihct_pkg;

  localparam int unsigned SlotBits = 10;
  localparam int unsigned Slots    = 1 << SlotBits;
  localparam int unsigned KeyBits  = 32;
  localparam int unsigned CodeBits = 30;
  localparam int unsigned TagShift = 2;
  localparam int unsigned CntBits  = SlotBits + 1;
  localparam int unsigned QDepth   = 2;

  localparam logic [CodeBits-1:0] LcgMul = CodeBits'(1664525);
  localparam logic [CodeBits-1:0] LcgAdd = CodeBits'(1013904234);

  typedef enum logic [1:0] {
    KIND_ASSIGN = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    MARK_EMPTY   = 2'd0,
    MARK_LIVE    = 2'd1,
    MARK_REMOVED = 2'd2,
    MARK_SPARE   = 2'd3
  } mark_e;

  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_ENLARGE   = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_FULL      = 3'd5
  } status_e;

  typedef enum logic [0:0] {
    REG_SEED = 1'd0,
    REG_LOAD = 1'd1
  } reg_e;

  // classified request handed from front to back
  typedef struct packed {
    logic                skip;
    kind_e               kind;
    logic [KeyBits-1:0]  key;
    logic [CodeBits-1:0] value;
    logic [SlotBits-1:0] home;
  } req_t;

  typedef enum logic [3:0] {
    BK_IDLE, BK_CLEAR, BK_READ, BK_CHECK, BK_LCG, BK_WRITE,
    BK_NBR, BK_NBR_WAIT, BK_NBR_CHK, BK_DONE
  } bk_state_e;

endpackage

[hdl/ihct_front.sv]
// front part: accepts requests, computes home slot, queues them for the back part
// depends on ihct_pkg
module ihct_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             kind_i,
  input  logic [31:0]            key_i,
  input  logic [29:0]            value_i,
  input  logic                   pop_i,
  output logic                   q_valid_o,
  output ihct_pkg::req_t         q_req_o,
  input  logic                   back_idle_i
);
  import ihct_pkg::*;

  req_t          q_mem [QDepth];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;
  logic          push;
  req_t          req;

  // classify incoming request
  always_comb begin
    req.skip  = (kind_i == KIND_NONE);
    req.kind  = kind_e'(kind_i);
    req.key   = key_i;
    req.value = value_i;
    req.home  = key_i[TagShift +: SlotBits];
  end

  // one request outstanding in the whole block
  assign busy      = (cnt_q != 2'd0) || !back_idle_i;
  assign push      = start && !busy;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_req_o   = q_mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_q] <= req;
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop_i);
    end
  end
endmodule

[hdl/ihct_back.sv]
// back part: probes the slot memories, inserts, removes and emits results
// depends on ihct_pkg
module ihct_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  input  ihct_pkg::req_t            q_req_i,
  output logic                      pop_o,
  output logic                      idle_o,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [29:0]               cfg_data_i,
  output logic                      done,
  output logic [2:0]                status_o,
  output logic [29:0]               hash_code_o,
  output logic [10:0]               live_count_o
);
  import ihct_pkg::*;

  // memories
  logic [1:0]          mark_mem [Slots];
  logic [KeyBits-1:0]  key_mem  [Slots];
  logic [CodeBits-1:0] code_mem [Slots];

  bk_state_e           st_q, st_d;
  req_t                req_q;
  logic [SlotBits-1:0] pos_q, rm_q, addr;
  logic [SlotBits:0]   n_q;
  logic                have_rm_q;
  logic [1:0]          m_rd_q;
  logic [KeyBits-1:0]  k_rd_q;
  logic [CodeBits-1:0] c_rd_q;
  logic                nbr_q;
  logic [CodeBits-1:0] gen_q, code_q;
  logic [6:0]          load_q;
  logic [CntBits-1:0]  cnt_q;
  logic [SlotBits-1:0] clr_q;
  logic [2:0]          stat_q;
  logic                hit, enlarge;
  logic [CntBits+6:0]  lhs, rhs;
  logic                mark_we;
  logic [1:0]          mark_wd;
  logic [SlotBits-1:0] mark_wa;

  assign hit = (m_rd_q == MARK_LIVE) && (k_rd_q == req_q.key);
  assign lhs = (CntBits+7)'(cnt_q) * (CntBits+7)'(100);
  assign rhs = (CntBits+7)'(Slots) * (CntBits+7)'(load_q);
  assign enlarge = lhs > rhs;

  // read address: probe position or neighbors
  always_comb begin
    addr = pos_q;
    if (st_q == BK_NBR) addr = pos_q + SlotBits'(1);
    else if (st_q == BK_NBR_WAIT) addr = pos_q - SlotBits'(1);
  end

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      BK_CLEAR:    if (clr_q == SlotBits'(Slots - 1)) st_d = BK_IDLE;
      BK_IDLE:     if (q_valid_i) st_d = q_req_i.skip ? BK_DONE : BK_READ;
      BK_READ:     st_d = BK_CHECK;
      BK_CHECK: begin
        if (n_q == (SlotBits+1)'(Slots)) st_d = BK_DONE;
        else if (m_rd_q == MARK_EMPTY) begin
          if (req_q.kind == KIND_REMOVE || enlarge) st_d = BK_DONE;
          else st_d = (req_q.kind == KIND_ASSIGN) ? BK_LCG : BK_WRITE;
        end else if (hit) st_d = (req_q.kind == KIND_REMOVE) ? BK_NBR : BK_DONE;
        else st_d = BK_READ;
      end
      BK_LCG:      st_d = BK_WRITE;
      BK_WRITE:    st_d = BK_DONE;
      BK_NBR:      st_d = BK_NBR_WAIT;
      BK_NBR_WAIT: st_d = BK_NBR_CHK;
      BK_NBR_CHK:  st_d = BK_DONE;
      BK_DONE:     st_d = BK_IDLE;
      default:     st_d = BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop_o   = (st_q == BK_IDLE) && q_valid_i;
    idle_o  = (st_q == BK_IDLE);
    mark_we = 1'b0;
    mark_wa = pos_q;
    mark_wd = MARK_LIVE;
    unique case (st_q)
      BK_CLEAR: begin
        mark_we = 1'b1; mark_wa = clr_q; mark_wd = MARK_EMPTY;
      end
      BK_WRITE: begin
        mark_we = 1'b1; mark_wa = have_rm_q ? rm_q : pos_q;
      end
      BK_NBR_CHK: begin
        mark_we = 1'b1;
        mark_wd = (nbr_q && m_rd_q == MARK_EMPTY) ? MARK_EMPTY : MARK_REMOVED;
      end
      default: ;
    endcase
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    m_rd_q <= mark_mem[addr];
    k_rd_q <= key_mem[addr];
    c_rd_q <= code_mem[addr];
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    if (st_q == BK_WRITE) begin
      key_mem[mark_wa]  <= req_q.key;
      code_mem[mark_wa] <= code_q;
    end
  end

  // datapath and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BK_CLEAR; clr_q <= '0; gen_q <= CodeBits'(1); load_q <= 7'd65;
      cnt_q <= '0; done <= 1'b0; stat_q <= ST_FOUND; hash_code_o <= '0;
      pos_q <= '0; rm_q <= '0; n_q <= '0; have_rm_q <= 1'b0; nbr_q <= 1'b0;
      code_q <= '0; req_q <= '0;
    end else begin
      st_q <= st_d;
      done <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_SEED) gen_q <= cfg_data_i;
        else load_q <= cfg_data_i[6:0];
      end
      unique case (st_q)
        BK_CLEAR: clr_q <= clr_q + SlotBits'(1);
        BK_IDLE: if (q_valid_i) begin
          req_q <= q_req_i; pos_q <= q_req_i.home; n_q <= '0;
          have_rm_q <= 1'b0; stat_q <= ST_NOT_FOUND; code_q <= q_req_i.value;
        end
        BK_CHECK: begin
          if (n_q == (SlotBits+1)'(Slots))
            stat_q <= (req_q.kind == KIND_REMOVE) ? ST_NOT_FOUND : ST_FULL;
          else if (m_rd_q == MARK_EMPTY) begin
            if (req_q.kind == KIND_REMOVE) stat_q <= ST_NOT_FOUND;
            else if (enlarge) stat_q <= ST_ENLARGE;
          end else if (hit) begin
            if (req_q.kind == KIND_REMOVE) stat_q <= ST_REMOVED;
            else begin stat_q <= ST_FOUND; code_q <= c_rd_q; end
          end else begin
            if (!have_rm_q && m_rd_q != MARK_LIVE) begin
              have_rm_q <= 1'b1; rm_q <= pos_q;
            end
            pos_q <= pos_q + SlotBits'(1);
            n_q   <= n_q + (SlotBits+1)'(1);
          end
        end
        BK_LCG: begin
          code_q <= CodeBits'(gen_q * LcgMul + LcgAdd);
          gen_q  <= CodeBits'(gen_q * LcgMul + LcgAdd);
        end
        BK_WRITE: begin stat_q <= ST_INSERTED; cnt_q <= cnt_q + CntBits'(1); end
        BK_NBR_WAIT: begin
          nbr_q <= (m_rd_q == MARK_EMPTY);
          if (cnt_q != '0) cnt_q <= cnt_q - CntBits'(1);
        end
        BK_DONE: begin
          done <= 1'b1;
          hash_code_o <= (stat_q == ST_FOUND || stat_q == ST_INSERTED) ? code_q : '0;
        end
        default: ;
      endcase
    end
  end

  assign status_o     = stat_q;
  assign live_count_o = cnt_q;
endmodule

[hdl/identity_hash_code_table_unit.sv]
// channel  | signals                         | handshake
// request  | kind_i key_i value_i            | start, busy
// result   | status_o hash_code_o live_count_o | done strobe, one cycle
// config   | cfg_we_i cfg_idx_i cfg_data_i   | write at enable
// a request passes from accept to result through a read and a check per probed
// slot (one memory read port), a write for a given-value insert, an LCG step
// and a write for a generated code and neighbor reads on a remove hit; the next
// request is taken in the result cycle; after reset a clearing pass sweeps the
// slot marks while busy is high; results cannot stall
// top level: depends on ihct_pkg, ihct_front, ihct_back
module identity_hash_code_table_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind_i,
  input  logic [31:0] key_i,
  input  logic [29:0] value_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [29:0] cfg_data_i,
  output logic        done,
  output logic [2:0]  status_o,
  output logic [29:0] hash_code_o,
  output logic [10:0] live_count_o
);
  import ihct_pkg::*;

  logic q_valid, pop, back_idle;
  req_t q_req;

  ihct_front u_front (
    .clk_i, .rst_ni, .start, .busy, .kind_i, .key_i, .value_i,
    .pop_i(pop), .q_valid_o(q_valid), .q_req_o(q_req), .back_idle_i(back_idle)
  );

  ihct_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_req_i(q_req), .pop_o(pop),
    .idle_o(back_idle), .cfg_we_i, .cfg_idx_i, .cfg_data_i, .done, .status_o,
    .hash_code_o, .live_count_o
  );

  // a result is always preceded by busy being high
  assert property (@(posedge clk_i) disable iff (!rst_ni) done |-> $past(busy))
    else $error("result without request");
  // request accepted raises busy
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("busy not raised");
  // non-result statuses carry a zero code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done && status_o != ST_FOUND && status_o != ST_INSERTED) |-> hash_code_o == '0)
    else $error("stray code");
endmodule
